// File: design/wildcard_pattern_matcher_assert.svh
// Assertion macros used by the wildcard pattern matcher top level.
`ifndef WILDCARD_PATTERN_MATCHER_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define WPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/wpm_pkg.sv
// Package with operation codes, special bytes and the token type of the matcher.
`default_nettype none
package wpm_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;
	localparam logic [1:0] OP_TEXT   = 2'd3;

	// Wildcard bytes of the pattern.
	localparam logic [7:0] STAR_BYTE  = 8'h2A;
	localparam logic [7:0] QMARK_BYTE = 8'h3F;

	// Token that moves one cell along the chain in every cycle while the chain is enabled.
	typedef struct packed {
		logic       vld;    // a transaction occupies this slot
		logic [1:0] op;     // operation code
		logic [7:0] ch;     // pattern or text byte
		logic       store;  // append that really writes a pattern byte
		logic       col;    // column bit of the last pattern cell passed so far
		logic       ovf;    // sticky overflow flag as seen by this transaction
	} tok_t;

endpackage
`default_nettype wire

// File: design/wpm_cell.sv
// One pattern position of the matcher: pattern byte, column bits and a token stage.
`default_nettype none
module wpm_cell
	import wpm_pkg::*;
#(
	parameter int IDX_W      = 6,
	parameter int CELL_INDEX = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire tok_t             tok_in,
	input  wire logic [IDX_W-1:0] idx_in,
	output tok_t                  tok_out,
	output logic      [IDX_W-1:0] idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

	logic [7:0]       pb_q;
	logic             vld_q;
	logic             diag_q;   // previous column bit of the prefix one shorter
	logic             col_q;    // previous column bit of this prefix
	tok_t             tok_q;
	logic [IDX_W-1:0] idx_q;

	logic       hit;
	logic [7:0] pb_eff;
	logic       vld_eff;
	logic       fresh;
	tok_t       tok_next;

	// Pattern contents as they stand after this transaction.
	always_comb begin
		hit     = (tok_in.op == OP_APPEND) && tok_in.store && (idx_in == MY_IDX);
		pb_eff  = hit ? tok_in.ch : pb_q;
		unique case (tok_in.op)
			OP_CLEAR:  vld_eff = 1'b0;
			OP_APPEND: vld_eff = vld_q | hit;
			default:   vld_eff = vld_q;
		endcase
	end

	// Column recurrence: text bytes advance it, every other operation rebuilds the
	// empty-text column.
	always_comb begin
		if (tok_in.op != OP_TEXT) begin
			fresh = tok_in.col && (pb_eff == STAR_BYTE);
		end else if (pb_eff == QMARK_BYTE) begin
			fresh = diag_q;
		end else if (pb_eff == STAR_BYTE) begin
			fresh = diag_q | col_q | tok_in.col;
		end else begin
			fresh = diag_q && (pb_eff == tok_in.ch);
		end
		tok_next     = tok_in;
		tok_next.col = vld_eff ? fresh : tok_in.col;
	end

	// Cell state follows each transaction that passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			diag_q <= 1'b0;
			col_q  <= 1'b0;
		end else if (en && tok_in.vld) begin
			vld_q  <= vld_eff;
			diag_q <= tok_in.col;
			col_q  <= fresh;
		end
	end

	// Pattern byte needs no reset; it is read only once the cell is valid.
	always_ff @(posedge clk) begin
		if (en && tok_in.vld && hit) begin
			pb_q <= tok_in.ch;
		end
	end

	// Token stage toward the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			idx_q <= '0;
		end else if (en) begin
			tok_q <= tok_next;
			idx_q <= idx_in;
		end
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule
`default_nettype wire

// File: design/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: entry logic, cell chain and output skid.
//
// Input channel s_*: tuser carries the operation (clear pattern, append pattern
// byte, start text, text byte), tdata carries the byte. Output channel m_*:
// one transaction for every start-text and text-byte operation, in input order,
// with the whole-pattern match bit and the sticky overflow flag. Clear and append
// produce no output transaction.
// Each operation walks through a chain of MAX_PATTERN cells, one cell per cycle
// while the chain is not held; cell k holds pattern byte k and its column bits
// and updates them as the transaction passes. A result passes the token stage
// of every cell and then the output register before it appears on m_tvalid.
// Throughput is one transaction per cycle while the output is taken.
// An output register with a one-entry skid buffer sits behind the chain, so the
// input keeps accepting while one result waits; the whole chain holds only once
// the skid buffer is full.
// Reset clears the pattern length, the overflow flag, every cell valid bit and
// the chain tokens; no clearing pass is needed and input is accepted at once.
`default_nettype none
module wildcard_pattern_matcher
	import wpm_pkg::*;
#(
	parameter int MAX_PATTERN = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] char_value
	input  wire logic [1:0] s_tuser,   // [1:0] operation
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             ovf_next;
	logic             full;
	logic             en;
	logic             accept;
	tok_t             entry_tok;

	tok_t             chain_tok [0:MAX_PATTERN];
	logic [IDX_W-1:0] chain_idx [0:MAX_PATTERN];

	logic       push;
	logic [1:0] push_data;
	logic       pop;
	logic       m_valid_q;
	logic [1:0] m_data_q;
	logic       sk_valid_q;
	logic [1:0] sk_data_q;

	// The chain advances as long as the skid buffer is free.
	assign en       = !sk_valid_q;
	assign s_tready = en;
	assign accept   = s_tvalid && s_tready;
	assign full     = (len_q == LEN_MAX);

	// Overflow flag as left by the incoming transaction.
	always_comb begin
		unique case (s_tuser)
			OP_CLEAR:  ovf_next = 1'b0;
			OP_APPEND: ovf_next = ovf_q | full;
			default:   ovf_next = ovf_q;
		endcase
	end

	// Token that enters the first cell.
	always_comb begin
		entry_tok.vld   = accept;
		entry_tok.op    = s_tuser;
		entry_tok.ch    = s_tdata;
		entry_tok.store = (s_tuser == OP_APPEND) && !full;
		entry_tok.col   = (s_tuser != OP_TEXT);
		entry_tok.ovf   = ovf_next;
	end

	// Pattern length and overflow flag, kept at the chain entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			ovf_q <= ovf_next;
			if (s_tuser == OP_CLEAR) begin
				len_q <= '0;
			end else if (entry_tok.store) begin
				len_q <= len_q + LEN_W'(1);
			end
		end
	end

	assign chain_tok[0] = entry_tok;
	assign chain_idx[0] = len_q[IDX_W-1:0];

	// Row of pattern cells.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		wpm_cell #(
			.IDX_W      (IDX_W),
			.CELL_INDEX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.tok_in  (chain_tok[k]),
			.idx_in  (chain_idx[k]),
			.tok_out (chain_tok[k+1]),
			.idx_out (chain_idx[k+1])
		);
	end

	// Results leave the chain for start-text and text-byte operations only.
	assign push = en && chain_tok[MAX_PATTERN].vld &&
		((chain_tok[MAX_PATTERN].op == OP_START) || (chain_tok[MAX_PATTERN].op == OP_TEXT));
	assign push_data = {chain_tok[MAX_PATTERN].ovf, chain_tok[MAX_PATTERN].col};
	assign pop       = m_valid_q && m_tready;

	// Output register with skid buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (!m_valid_q || pop) begin
			if (sk_valid_q) begin
				m_valid_q  <= 1'b1;
				sk_valid_q <= 1'b0;
			end else begin
				m_valid_q <= push;
			end
		end else if (push) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_valid_q || pop) begin
			if (sk_valid_q) begin
				m_data_q <= sk_data_q;
			end else if (push) begin
				m_data_q <= push_data;
			end
		end else if (push) begin
			sk_data_q <= push_data;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, m_data_q};

	// Checks on the entry bookkeeping and the output buffer.
`include "wildcard_pattern_matcher_assert.svh"

	`WPM_ASSERT_NOW(a_len_bound, 1'b1, len_q <= LEN_MAX, "pattern length beyond capacity")
	`WPM_ASSERT_NEXT(a_clear_len, accept && (s_tuser == OP_CLEAR), (len_q == '0) && !ovf_q, "clear did not empty the pattern")
	`WPM_ASSERT_NEXT(a_full_ovf, accept && (s_tuser == OP_APPEND) && full, ovf_q && full, "append at capacity did not set overflow")
	`WPM_ASSERT_NOW(a_skid_behind, sk_valid_q, m_valid_q, "skid buffer holds data while output register is empty")

endmodule
`default_nettype wire
